>>> rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies; every other file imports this package.
package rmq_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int W    = DATA_WIDTH;
    localparam int FRAC = W - 2;
    localparam int AW   = W + 3;        // root argument, signed
    localparam int VW   = 2 * W;        // argument shifted up by FRAC
    localparam int RMW  = W + 2;        // square root partial remainder
    localparam int NW   = 2 * W;        // divider numerator
    localparam int QB   = W + 1;        // quotient bits produced per lane

    localparam logic [AW-1:0]  ONE_ARG  = AW'(1) << FRAC;
    localparam logic [W-1:0]   SMAX_W   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   SMIN_W   = {1'b1, {(W-1){1'b0}}};
    localparam logic [QB-1:0]  SMAX_Q   = QB'(SMAX_W);
    localparam logic [QB-1:0]  HALF_Q   = QB'(SMIN_W);

    typedef enum logic [1:0] {
        ROOT_X = 2'd0,
        ROOT_Y = 2'd1,
        ROOT_Z = 2'd2,
        ROOT_W = 2'd3
    } t_root;

    typedef struct packed {
        logic signed [W-1:0] m00;
        logic signed [W-1:0] m01;
        logic signed [W-1:0] m02;
        logic signed [W-1:0] m10;
        logic signed [W-1:0] m11;
        logic signed [W-1:0] m12;
        logic signed [W-1:0] m20;
        logic signed [W-1:0] m21;
        logic signed [W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] qx;
        logic signed [W-1:0] qy;
        logic signed [W-1:0] qz;
        logic signed [W-1:0] qw;
        logic                bad_root;
    } t_out;

    // square root section: three off-diagonal lanes ride along
    typedef struct packed {
        logic                bad;
        t_root               root;
        logic [2:0]          neg;
        logic [2:0][W:0]     mag;
        logic [VW-1:0]       v;
        logic [RMW-1:0]      rem;
        logic [W-1:0]        res;
    } t_sq;

    // divider section: three lanes share the divisor 2R
    typedef struct packed {
        logic                bad;
        t_root               root;
        logic [W-1:0]        r;
        logic [2:0]          neg;
        logic [2:0]          ovf;
        logic [2:0][NW-1:0]  n;
        logic [2:0][W:0]     rem;
        logic [2:0][QB-1:0]  quot;
    } t_dv;

endpackage

>>> rtl/rmq_front.sv
`timescale 1ns / 1ps
// Input stage: branch choice, root argument and off-diagonal sums.
// Depends on rmq_pkg.
module rmq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_sq  o_data
);
    import rmq_pkg::*;

    logic              r_valid;
    t_sq               r_data;
    t_sq               n_data;
    logic signed [AW-1:0] a00, a11, a22, trace, arg;
    t_root             root;
    logic [W:0]        d_xw, d_yw, d_zw, s01_10, s02_20, s12_21;
    logic [2:0][W:0]   d;

    assign a00   = AW'(i_data.m00);
    assign a11   = AW'(i_data.m11);
    assign a22   = AW'(i_data.m22);
    assign trace = a00 + a11 + a22;

    // W+1 bit sums and differences of two sign-extended elements
    assign d_xw   = {i_data.m21[W-1], i_data.m21} - {i_data.m12[W-1], i_data.m12};
    assign d_yw   = {i_data.m02[W-1], i_data.m02} - {i_data.m20[W-1], i_data.m20};
    assign d_zw   = {i_data.m10[W-1], i_data.m10} - {i_data.m01[W-1], i_data.m01};
    assign s01_10 = {i_data.m01[W-1], i_data.m01} + {i_data.m10[W-1], i_data.m10};
    assign s02_20 = {i_data.m02[W-1], i_data.m02} + {i_data.m20[W-1], i_data.m20};
    assign s12_21 = {i_data.m12[W-1], i_data.m12} + {i_data.m21[W-1], i_data.m21};

    always_comb begin
        if (!trace[AW-1]) begin
            root = ROOT_W;
        end else if (a11 > a00) begin
            root = (a22 > a11) ? ROOT_Z : ROOT_Y;
        end else begin
            root = (a22 > a00) ? ROOT_Z : ROOT_X;
        end
    end

    always_comb begin
        case (root)
            ROOT_W: begin
                arg = trace + $signed(ONE_ARG);
                d   = {d_zw, d_yw, d_xw};
            end
            ROOT_X: begin
                arg = a00 - a11 - a22 + $signed(ONE_ARG);
                d   = {d_xw, s02_20, s01_10};
            end
            ROOT_Y: begin
                arg = a11 - a22 - a00 + $signed(ONE_ARG);
                d   = {d_yw, s12_21, s01_10};
            end
            default: begin
                arg = a22 - a00 - a11 + $signed(ONE_ARG);
                d   = {d_zw, s12_21, s02_20};
            end
        endcase
    end

    always_comb begin
        n_data      = '0;
        n_data.bad  = arg[AW-1] || (arg == '0);
        n_data.root = root;
        n_data.v    = {arg[W+1:0], {FRAC{1'b0}}};
        for (int k = 0; k < 3; k++) begin
            n_data.neg[k] = d[k][W];
            n_data.mag[k] = d[k][W] ? (~d[k] + 1'b1) : d[k];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rmq_sqrt_step.sv
`timescale 1ns / 1ps
// One registered digit of the restoring square root (one result bit).
// Depends on rmq_pkg.
module rmq_sqrt_step #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_sq  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_sq  o_data
);
    import rmq_pkg::*;

    localparam int PAIR = W - 1 - STEP;

    logic           r_valid;
    t_sq            r_data;
    t_sq            n_data;
    logic [RMW+1:0] rem2;
    logic [RMW+1:0] trial;

    assign rem2  = {i_data.rem, i_data.v[2*PAIR+1 -: 2]};
    assign trial = (RMW+2)'({i_data.res, 2'b01});

    always_comb begin
        n_data = i_data;
        if (rem2 >= trial) begin
            n_data.rem = RMW'(rem2 - trial);
            n_data.res = {i_data.res[W-2:0], 1'b1};
        end else begin
            n_data.rem = RMW'(rem2);
            n_data.res = {i_data.res[W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rmq_div_prep.sv
`timescale 1ns / 1ps
// Divider setup: numerators |D|<<FRAC + R, divisor 2R, quotient overflow test.
// Depends on rmq_pkg.
module rmq_div_prep (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_sq  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_dv  o_data
);
    import rmq_pkg::*;

    logic        r_valid;
    t_dv         r_data;
    t_dv         n_data;
    logic [W:0]  dvs;
    logic [2:0][NW-1:0] num;

    assign dvs = {i_data.res, 1'b0};

    always_comb begin
        n_data      = '0;
        n_data.bad  = i_data.bad;
        n_data.root = i_data.root;
        n_data.r    = i_data.res;
        n_data.neg  = i_data.neg;
        for (int k = 0; k < 3; k++) begin
            num[k]         = {i_data.mag[k], {FRAC{1'b0}}} + NW'(i_data.res);
            n_data.n[k]    = num[k];
            // quotient needs more than QB bits when the top part already reaches 2R
            n_data.ovf[k]  = (W+1)'(num[k][NW-1:QB]) >= dvs;
            n_data.rem[k]  = (W+1)'(num[k][NW-1:QB]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rmq_div_step.sv
`timescale 1ns / 1ps
// One registered quotient bit of restoring division, three lanes at once.
// Depends on rmq_pkg.
module rmq_div_step #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_dv  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_dv  o_data
);
    import rmq_pkg::*;

    localparam int NBIT = QB - 1 - STEP;

    logic              r_valid;
    t_dv               r_data;
    t_dv               n_data;
    logic [W+1:0]      dvs;
    logic [2:0][W+1:0] rem2;

    assign dvs = {1'b0, i_data.r, 1'b0};

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < 3; k++) begin
            rem2[k] = {i_data.rem[k], i_data.n[k][NBIT]};
            if (rem2[k] >= dvs) begin
                n_data.rem[k]  = (W+1)'(rem2[k] - dvs);
                n_data.quot[k] = {i_data.quot[k][QB-2:0], 1'b1};
            end else begin
                n_data.rem[k]  = (W+1)'(rem2[k]);
                n_data.quot[k] = {i_data.quot[k][QB-2:0], 1'b0};
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rmq_back.sv
`timescale 1ns / 1ps
// Output stage: sign, saturation, component placement, output register.
// Depends on rmq_pkg.
module rmq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_dv  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_out o_data
);
    import rmq_pkg::*;

    logic            r_valid;
    t_out            r_data;
    t_out            n_data;
    logic [2:0][W-1:0] lane;
    logic [W:0]      rp;
    logic [W-1:0]    rv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_data.neg[k]) begin
                if (i_data.ovf[k] || (i_data.quot[k] > HALF_Q)) begin
                    lane[k] = SMIN_W;
                end else begin
                    lane[k] = W'(~i_data.quot[k] + 1'b1);
                end
            end else begin
                if (i_data.ovf[k] || (i_data.quot[k] > SMAX_Q)) begin
                    lane[k] = SMAX_W;
                end else begin
                    lane[k] = i_data.quot[k][W-1:0];
                end
            end
        end
    end

    // root component: R/2 rounded half up
    assign rp = ({1'b0, i_data.r} + 1'b1) >> 1;
    assign rv = (rp > (W+1)'(SMAX_W)) ? SMAX_W : rp[W-1:0];

    always_comb begin
        n_data = '0;
        if (i_data.bad) begin
            n_data.bad_root = 1'b1;
        end else begin
            case (i_data.root)
                ROOT_W: begin
                    n_data.qx = lane[0];
                    n_data.qy = lane[1];
                    n_data.qz = lane[2];
                    n_data.qw = rv;
                end
                ROOT_X: begin
                    n_data.qx = rv;
                    n_data.qy = lane[0];
                    n_data.qz = lane[1];
                    n_data.qw = lane[2];
                end
                ROOT_Y: begin
                    n_data.qx = lane[0];
                    n_data.qy = rv;
                    n_data.qz = lane[1];
                    n_data.qw = lane[2];
                end
                default: begin
                    n_data.qx = lane[0];
                    n_data.qy = lane[1];
                    n_data.qz = rv;
                    n_data.qw = lane[2];
                end
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Rotation matrix to quaternion converter, Q1.14 fixed point.
// Depends on rmq_pkg and the rmq_* stage modules.
//
// Input channel: i_valid / o_ready with i_data, the nine matrix elements
// in row-major order. Output channel: o_valid / i_ready with o_data, the
// quaternion (qx, qy, qz, qw) and the bad_root flag. A transfer happens on
// a rising edge with valid and ready both high.
//
// The pipeline has one setup stage, one stage per root bit, one divider
// setup stage, one stage per quotient bit (DATA_WIDTH+1) and the output
// register. Throughput is one item per cycle while i_ready stays high.
//
// Every stage holds a valid bit and takes new data whenever it is empty or
// its successor takes its contents, so bubbles close up while the receiver
// stalls; when the pipeline is full, o_ready drops and nothing is lost.
// Synchronous active-low reset clears all valid bits; the pipeline is empty
// and ready after reset.
module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rmq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rmq_pkg::t_out o_data
);
    import rmq_pkg::*;

    logic [W:0]  sq_v;
    logic [W:0]  sq_rdy;
    t_sq         sq_d [W+1];
    logic [QB:0] dv_v;
    logic [QB:0] dv_rdy;
    t_dv         dv_d [QB+1];

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (sq_v[0]),
        .i_ready (sq_rdy[0]),
        .o_data  (sq_d[0])
    );

    for (genvar s = 0; s < W; s++) begin : g_sqrt
        rmq_sqrt_step #(.STEP(s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[s]),
            .o_ready (sq_rdy[s]),
            .i_data  (sq_d[s]),
            .o_valid (sq_v[s+1]),
            .i_ready (sq_rdy[s+1]),
            .o_data  (sq_d[s+1])
        );
    end

    rmq_div_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v[W]),
        .o_ready (sq_rdy[W]),
        .i_data  (sq_d[W]),
        .o_valid (dv_v[0]),
        .i_ready (dv_rdy[0]),
        .o_data  (dv_d[0])
    );

    for (genvar s = 0; s < QB; s++) begin : g_div
        rmq_div_step #(.STEP(s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[s]),
            .o_ready (dv_rdy[s]),
            .i_data  (dv_d[s]),
            .o_valid (dv_v[s+1]),
            .i_ready (dv_rdy[s+1]),
            .o_data  (dv_d[s+1])
        );
    end

    rmq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_v[QB]),
        .o_ready (dv_rdy[QB]),
        .i_data  (dv_d[QB]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule

>>> tb/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// an in-bench fixed-point quaternion predictor and an in-order result check.
// Depends on rmq_pkg and the RTL of the block.
module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int LATENCY = 2 * DATA_WIDTH + 4;
    localparam int N_RANDOM = 1600;
    localparam int HOLD_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    t_in matrix_q[$];
    t_out quat_q[$];
    int n_errors = 0;
    bit calm = 1'b0;        // no random idling while set
    bit hold_rx = 1'b0;     // receiver holds off while set
    bit pause_tx = 1'b0;    // sender pauses while set

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint sat_q(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (W - 1)) - 1;
        lo = -(longint'(1) <<< (W - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // d / (2r), half rounded away from zero
    function automatic longint div_by_2r(longint d, longint unsigned r);
        longint unsigned mag, q;
        mag = (d < 0) ? longint'(-d) : d;
        q = ((mag << FRAC) + r) / (2 * r);
        if (q > (64'd1 << W)) q = 64'd1 << W;
        return sat_q((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_out quat_of(t_in mi);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, arg, one;
        longint q[4];
        longint unsigned r;
        t_root root;
        t_out o;
        a00 = mi.m00; a01 = mi.m01; a02 = mi.m02;
        a10 = mi.m10; a11 = mi.m11; a12 = mi.m12;
        a20 = mi.m20; a21 = mi.m21; a22 = mi.m22;
        one = longint'(1) <<< FRAC;
        o = '0;
        if (a00 + a11 + a22 >= 0) begin
            root = ROOT_W; arg = a00 + a11 + a22 + one;
        end else if (a11 > a00) begin
            if (a22 > a11) begin
                root = ROOT_Z; arg = a22 - a00 - a11 + one;
            end else begin
                root = ROOT_Y; arg = a11 - a22 - a00 + one;
            end
        end else if (a22 > a00) begin
            root = ROOT_Z; arg = a22 - a00 - a11 + one;
        end else begin
            root = ROOT_X; arg = a00 - a11 - a22 + one;
        end
        if (arg <= 0) begin
            o.bad_root = 1'b1;
            return o;
        end
        r = int_sqrt(longint'(arg) << FRAC);
        case (root)
            ROOT_W: begin
                q[0] = div_by_2r(a21 - a12, r);
                q[1] = div_by_2r(a02 - a20, r);
                q[2] = div_by_2r(a10 - a01, r);
            end
            ROOT_X: begin
                q[1] = div_by_2r(a01 + a10, r);
                q[2] = div_by_2r(a02 + a20, r);
                q[3] = div_by_2r(a21 - a12, r);
            end
            ROOT_Y: begin
                q[0] = div_by_2r(a01 + a10, r);
                q[2] = div_by_2r(a12 + a21, r);
                q[3] = div_by_2r(a02 - a20, r);
            end
            default: begin
                q[0] = div_by_2r(a20 + a02, r);
                q[1] = div_by_2r(a12 + a21, r);
                q[3] = div_by_2r(a10 - a01, r);
            end
        endcase
        q[root] = sat_q(longint'((r + 1) >> 1));
        o.qx = q[0][W-1:0];
        o.qy = q[1][W-1:0];
        o.qz = q[2][W-1:0];
        o.qw = q[3][W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 10);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (matrix_q.size() > 0 && !pause_tx && !idle_now()) begin
                i_data <= matrix_q[0];
                quat_q.push_back(quat_of(matrix_q[0]));
                void'(matrix_q.pop_front());
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver ready
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (quat_q.size() == 0) begin
                report_mismatch("extra transfer", 1, 0);
            end else begin
                want = quat_q.pop_front();
                if (o_data.qx !== want.qx) report_mismatch("qx", o_data.qx, want.qx);
                if (o_data.qy !== want.qy) report_mismatch("qy", o_data.qy, want.qy);
                if (o_data.qz !== want.qz) report_mismatch("qz", o_data.qz, want.qz);
                if (o_data.qw !== want.qw) report_mismatch("qw", o_data.qw, want.qw);
                if (o_data.bad_root !== want.bad_root)
                    report_mismatch("bad_root", o_data.bad_root, want.bad_root);
            end
        end
        i_ready <= i_rst_n && !hold_rx && !idle_now();
    end

    function automatic t_in rand_matrix();
        t_in mi;
        logic [W-1:0] e;
        for (int k = 0; k < 9; k++) begin
            case ($urandom_range(3))
                0: e = W'($urandom);
                // near identity-like values, within [-1, 1]
                1, 2: e = W'($signed($urandom_range(2 << FRAC)) - (1 << FRAC));
                default: e = ($urandom_range(1)) ? SMAX_W : SMIN_W;
            endcase
            mi[(8 - k) * W +: W] = e;
        end
        return mi;
    endfunction

    function automatic t_in diag(int d0, int d1, int d2, int off);
        t_in mi;
        mi = '0;
        mi.m00 = W'(d0); mi.m11 = W'(d1); mi.m22 = W'(d2);
        mi.m01 = W'(off); mi.m10 = W'(-off); mi.m02 = W'(off / 2);
        mi.m20 = W'(off / 3); mi.m12 = W'(-off / 5); mi.m21 = W'(off / 7);
        return mi;
    endfunction

    initial begin
        t_in mi;
        int one;
        one = 1 << FRAC;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: each root branch, ties, extremes
        matrix_q.push_back(diag(one, one, one, 0));
        matrix_q.push_back(diag(one, -one, -one, 1000));       // x branch
        matrix_q.push_back(diag(-one, one, -one, 1000));       // y branch
        matrix_q.push_back(diag(-one, -one, one, 1000));       // z with m11 tied to m00
        matrix_q.push_back(diag(-one, -one + 5, one, 300));    // z via m11 > m00, m22 > m11
        matrix_q.push_back(diag(-100, -200, 50, 77));          // z with m11 <= m00
        matrix_q.push_back(diag(-100, -100, -100, 9));         // all tied
        matrix_q.push_back(diag(-200, -100, -100, 9));         // m22 ties m11
        matrix_q.push_back(diag(-100, -200, -100, 9));         // m22 ties m00
        matrix_q.push_back(diag(-one, -one, -one, 0));         // trace < 0, all tied
        matrix_q.push_back(diag(-32768, -32768, -32768, 0));   // most negative diagonal
        matrix_q.push_back(diag(0, 0, 0, 0));
        matrix_q.push_back(diag(-one / 3, -one / 3, -one / 3 - 1, 5));
        mi = '1; matrix_q.push_back(mi);
        mi = '0; matrix_q.push_back(mi);
        mi = {9{SMAX_W}}; matrix_q.push_back(mi);
        mi = {9{SMIN_W}}; matrix_q.push_back(mi);
        mi = diag(32767, -32768, -32768, 32767); matrix_q.push_back(mi);
        mi = diag(2, 0, 0, -32768); matrix_q.push_back(mi);
        mi = diag(-32768, -32768, 32767, 32767); matrix_q.push_back(mi);
        // long calm stretch: no idling on either side
        calm = 1'b1;
        for (int n = 0; n < 300; n++) matrix_q.push_back(rand_matrix());
        wait (matrix_q.size() == 0);
        calm = 1'b0;
        // receiver holds off while the sender keeps offering
        hold_rx = 1'b1;
        for (int n = 0; n < 200; n++) matrix_q.push_back(rand_matrix());
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
        hold_rx = 1'b0;
        wait (matrix_q.size() == 0);
        // sender pauses until everything has drained
        pause_tx = 1'b1;
        for (int n = 0; n < 1100; n++) matrix_q.push_back(rand_matrix());
        wait (quat_q.size() == 0);
        pause_tx = 1'b0;
        wait (matrix_q.size() == 0);
        wait (quat_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> rotation_matrix_to_quaternion.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt_step.sv
rtl/rmq_div_prep.sv
rtl/rmq_div_step.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
tb/tb_rotation_matrix_to_quaternion.sv
